>>> design/rsi_pkg.sv
// shared constants, types and the control program of the relative strength index block
package rsi_pkg;

    // default parameter values
    localparam int PRICE_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int PERIOD_MAX_DEF = 255;

    // fixed widths
    localparam int AVG_BITS = 48;
    localparam int PER_W    = 8;
    localparam int RSI_W    = 15;

    localparam logic [RSI_W-1:0] RSI_FULL     = 15'd25600;
    localparam logic [RSI_W-1:0] RSI_NEUTRAL  = 15'd12800;
    localparam logic [PER_W-1:0] PERIOD_RESET = 8'd14;

    // divider lanes
    localparam int LANES     = 2;
    localparam int LANE_GAIN = 0;
    localparam int LANE_LOSS = 1;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_CHANGE,
        OP_ACCUM,
        OP_LOAD_WARM,
        OP_DIV,
        OP_STORE_AVG,
        OP_MUL,
        OP_LOAD_SMOOTH,
        OP_RSUM,
        OP_LOAD_RSI,
        OP_STORE_RSI,
        OP_EMIT
    } op_t;

    // jump conditions
    typedef enum logic [3:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_NO_ITEM,
        CND_START,
        CND_WARMED,
        CND_STILL_WARM,
        CND_DIV_MORE,
        CND_LOSS_ZERO,
        CND_OUT_BUSY
    } cond_t;

    typedef logic [3:0] step_t;

    // program steps
    localparam step_t ST_IDLE   = 4'd0;
    localparam step_t ST_CHANGE = 4'd1;
    localparam step_t ST_CHECK  = 4'd2;
    localparam step_t ST_ACCUM  = 4'd3;
    localparam step_t ST_WLOAD  = 4'd4;
    localparam step_t ST_WDIV   = 4'd5;
    localparam step_t ST_WSTORE = 4'd6;
    localparam step_t ST_SMUL   = 4'd7;
    localparam step_t ST_SLOAD  = 4'd8;
    localparam step_t ST_SDIV   = 4'd9;
    localparam step_t ST_SSTORE = 4'd10;
    localparam step_t ST_RSUM   = 4'd11;
    localparam step_t ST_RLOAD  = 4'd12;
    localparam step_t ST_RDIV   = 4'd13;
    localparam step_t ST_RSTORE = 4'd14;
    localparam step_t ST_EMIT   = 4'd15;

    // one control word: operation, jump condition, jump target (else next step)
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    // control program; the step after the last wraps to idle
    function automatic ucode_t ucode_rom(input step_t pc);
        ucode_t w;
        case (pc)
            ST_IDLE:   w = '{op: OP_NOP,         cond: CND_NO_ITEM,    target: ST_IDLE};
            ST_CHANGE: w = '{op: OP_CHANGE,      cond: CND_START,      target: ST_EMIT};
            ST_CHECK:  w = '{op: OP_NOP,         cond: CND_WARMED,     target: ST_SMUL};
            ST_ACCUM:  w = '{op: OP_ACCUM,       cond: CND_STILL_WARM, target: ST_EMIT};
            ST_WLOAD:  w = '{op: OP_LOAD_WARM,   cond: CND_NEVER,      target: ST_IDLE};
            ST_WDIV:   w = '{op: OP_DIV,         cond: CND_DIV_MORE,   target: ST_WDIV};
            ST_WSTORE: w = '{op: OP_STORE_AVG,   cond: CND_ALWAYS,     target: ST_RSUM};
            ST_SMUL:   w = '{op: OP_MUL,         cond: CND_NEVER,      target: ST_IDLE};
            ST_SLOAD:  w = '{op: OP_LOAD_SMOOTH, cond: CND_NEVER,      target: ST_IDLE};
            ST_SDIV:   w = '{op: OP_DIV,         cond: CND_DIV_MORE,   target: ST_SDIV};
            ST_SSTORE: w = '{op: OP_STORE_AVG,   cond: CND_NEVER,      target: ST_IDLE};
            ST_RSUM:   w = '{op: OP_RSUM,        cond: CND_LOSS_ZERO,  target: ST_EMIT};
            ST_RLOAD:  w = '{op: OP_LOAD_RSI,    cond: CND_NEVER,      target: ST_IDLE};
            ST_RDIV:   w = '{op: OP_DIV,         cond: CND_DIV_MORE,   target: ST_RDIV};
            ST_RSTORE: w = '{op: OP_STORE_RSI,   cond: CND_NEVER,      target: ST_IDLE};
            ST_EMIT:   w = '{op: OP_EMIT,        cond: CND_OUT_BUSY,   target: ST_EMIT};
            default:   w = '{op: OP_NOP,         cond: CND_NEVER,      target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> design/relative_strength_index.sv
// relative strength index top level: microcoded sequencer, divider lanes and output register
//
// channel   direction  beat contents                          handshake
// s_        in         s_close_price, s_series_start          s_valid / s_ready
// m_        out        m_rsi_value, m_ready_res               m_valid / m_ready
// cfg_      in         cfg_averaging_period                   cfg_valid / cfg_ready
//
// one item at a time; s_ready and cfg_ready are high only in the idle step.
// work between accepting an item and presenting its result beat:
//   a steady smoothing item runs two restoring divisions of one bit per cycle
//   (averages 48 steps, index 15 steps); the item that ends warm-up runs a 64-step
//   averages division in place of the smoothing one; a zero average loss skips the
//   index division; other warm-up items and series-start items skip both divisions.
// the program is back in idle on the edge that presents the result, so s_ready is
//   already high while the result beat is shown; the program holds in its last step
//   only while the output register is full and m_ready is low.
// reset is synchronous, active low; no clearing pass.
module relative_strength_index #(
    parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEF,
    parameter int FRAC_BITS  = rsi_pkg::FRAC_BITS_DEF,
    parameter int PERIOD_MAX = rsi_pkg::PERIOD_MAX_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input items
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [PRICE_BITS-1:0]       s_close_price,
    input  logic                        s_series_start,
    // results
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rsi_pkg::RSI_W-1:0]   m_rsi_value,
    output logic                        m_ready_res,
    // configuration
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rsi_pkg::PER_W-1:0]   cfg_averaging_period
);
    import rsi_pkg::*;

    localparam int AVG_W    = AVG_BITS;
    localparam int X_W      = PRICE_BITS + FRAC_BITS;
    localparam int SMOOTH_Q = (X_W > AVG_W) ? X_W : AVG_W;
    localparam int WARM_Q   = AVG_W + FRAC_BITS;
    localparam int DVD_A    = (WARM_Q > SMOOTH_Q + PER_W) ? WARM_Q : SMOOTH_Q + PER_W;
    localparam int DVD_W    = (DVD_A > RSI_W + AVG_W) ? DVD_A : RSI_W + AVG_W;
    localparam int DIV_W    = AVG_W + 1;
    localparam int CNT_W    = $clog2(DVD_W + 1);
    localparam int MUL_W    = AVG_W + PER_W;

    // sequencer
    step_t  pc_reg, pc_next;
    ucode_t ctrl;
    logic   taken;

    // configuration and series state
    logic [PER_W-1:0]      period_reg, period_next;
    logic [PRICE_BITS-1:0] prev_reg, prev_next;
    logic [PER_W-1:0]      idx_reg, idx_next;
    logic [AVG_W-1:0]      avg_reg [LANES];
    logic [AVG_W-1:0]      avg_next [LANES];

    // captured item and changes
    logic [PRICE_BITS-1:0] close_reg, close_next;
    logic                  start_reg, start_next;
    logic [PRICE_BITS-1:0] chg_reg [LANES];
    logic [PRICE_BITS-1:0] chg_next [LANES];

    // divider lanes
    logic [DVD_W-1:0] dvd_reg [LANES];
    logic [DVD_W-1:0] dvd_next [LANES];
    logic [DIV_W-1:0] rem_reg [LANES];
    logic [DIV_W-1:0] rem_next [LANES];
    logic [DIV_W-1:0] div_reg [LANES];
    logic [DIV_W-1:0] div_next [LANES];
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // pending result and output register
    logic [RSI_W-1:0] res_rsi_reg, res_rsi_next;
    logic             res_rdy_reg, res_rdy_next;
    logic             m_valid_reg, m_valid_next;
    logic [RSI_W-1:0] m_rsi_reg, m_rsi_next;
    logic             m_rdy_reg, m_rdy_next;

    // helpers
    logic [PER_W-1:0] p_raw, p_eff, p_m1;
    logic             warmed, still_warm, out_busy;
    logic [DIV_W+1:0] trial [LANES];
    logic             qbit [LANES];
    logic [MUL_W-1:0] prod [LANES];
    logic [DVD_W-1:0] ld_val [LANES];
    logic [DVD_W-1:0] rsi_dvd;

    // effective period: zero reads as one, clamp at the maximum
    always_comb begin
        p_raw = (period_reg == '0) ? PER_W'(1) : period_reg;
        p_eff = (32'(p_raw) > PERIOD_MAX) ? PER_W'(PERIOD_MAX) : p_raw;
        p_m1  = p_eff - PER_W'(1);
    end

    assign warmed     = (idx_reg >= p_eff);
    assign still_warm = ({1'b0, idx_reg} + (PER_W + 1)'(1)) < {1'b0, p_eff};
    assign out_busy   = m_valid_reg && !m_ready;

    assign s_ready   = (pc_reg == ST_IDLE);
    assign cfg_ready = (pc_reg == ST_IDLE);

    // control word fetch and jump decision
    always_comb begin
        ctrl = ucode_rom(pc_reg);
        case (ctrl.cond)
            CND_NEVER:      taken = 1'b0;
            CND_ALWAYS:     taken = 1'b1;
            CND_NO_ITEM:    taken = !s_valid;
            CND_START:      taken = start_reg;
            CND_WARMED:     taken = warmed;
            CND_STILL_WARM: taken = still_warm;
            CND_DIV_MORE:   taken = (cnt_reg != CNT_W'(1));
            CND_LOSS_ZERO:  taken = (avg_reg[LANE_LOSS] == '0);
            CND_OUT_BUSY:   taken = out_busy;
            default:        taken = 1'b0;
        endcase
        pc_next = taken ? ctrl.target : pc_reg + step_t'(1);
    end

    // restoring divide step and smoothing multiply per lane
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            trial[l] = {1'b0, rem_reg[l], dvd_reg[l][DVD_W-1]} - {2'b00, div_reg[l]};
            qbit[l]  = !trial[l][DIV_W+1];
            prod[l]  = {{PER_W{1'b0}}, avg_reg[l]} * {{AVG_W{1'b0}}, p_m1};
        end
    end

    // 25600 * gain as 2^14 + 2^13 + 2^10
    assign rsi_dvd = (DVD_W'(avg_reg[LANE_GAIN]) << 14) + (DVD_W'(avg_reg[LANE_GAIN]) << 13)
                   + (DVD_W'(avg_reg[LANE_GAIN]) << 10);

    // datapath next values
    always_comb begin
        period_next  = period_reg;
        prev_next    = prev_reg;
        idx_next     = idx_reg;
        close_next   = close_reg;
        start_next   = start_reg;
        cnt_next     = cnt_reg;
        res_rsi_next = res_rsi_reg;
        res_rdy_next = res_rdy_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_rsi_next   = m_rsi_reg;
        m_rdy_next   = m_rdy_reg;
        for (int l = 0; l < LANES; l++) begin
            avg_next[l] = avg_reg[l];
            chg_next[l] = chg_reg[l];
            dvd_next[l] = dvd_reg[l];
            rem_next[l] = rem_reg[l];
            div_next[l] = div_reg[l];
            ld_val[l]   = '0;
        end

        // register write
        if (cfg_valid && cfg_ready) begin
            period_next = cfg_averaging_period;
        end

        // capture an input beat
        if (s_valid && s_ready) begin
            close_next = s_close_price;
            start_next = s_series_start;
        end

        case (ctrl.op)
            OP_CHANGE: begin
                res_rsi_next = RSI_NEUTRAL;
                res_rdy_next = 1'b0;
                prev_next    = close_reg;
                if (start_reg) begin
                    idx_next            = '0;
                    avg_next[LANE_GAIN] = '0;
                    avg_next[LANE_LOSS] = '0;
                end else begin
                    chg_next[LANE_GAIN] = (close_reg > prev_reg) ? close_reg - prev_reg : '0;
                    chg_next[LANE_LOSS] = (prev_reg > close_reg) ? prev_reg - close_reg : '0;
                end
            end
            OP_ACCUM: begin
                idx_next = idx_reg + PER_W'(1);
                for (int l = 0; l < LANES; l++) begin
                    avg_next[l] = avg_reg[l] + AVG_W'(chg_reg[l]);
                end
            end
            OP_LOAD_WARM: begin
                cnt_next = CNT_W'(WARM_Q);
                for (int l = 0; l < LANES; l++) begin
                    ld_val[l]   = DVD_W'(avg_reg[l]) << FRAC_BITS;
                    rem_next[l] = DIV_W'(ld_val[l] >> WARM_Q);
                    dvd_next[l] = ld_val[l] << (DVD_W - WARM_Q);
                    div_next[l] = DIV_W'(p_eff);
                end
            end
            OP_MUL: begin
                for (int l = 0; l < LANES; l++) begin
                    dvd_next[l] = DVD_W'(prod[l]);
                end
            end
            OP_LOAD_SMOOTH: begin
                cnt_next = CNT_W'(SMOOTH_Q);
                for (int l = 0; l < LANES; l++) begin
                    ld_val[l]   = dvd_reg[l] + (DVD_W'(chg_reg[l]) << FRAC_BITS);
                    rem_next[l] = DIV_W'(ld_val[l] >> SMOOTH_Q);
                    dvd_next[l] = ld_val[l] << (DVD_W - SMOOTH_Q);
                    div_next[l] = DIV_W'(p_eff);
                end
            end
            OP_DIV: begin
                cnt_next = cnt_reg - CNT_W'(1);
                for (int l = 0; l < LANES; l++) begin
                    rem_next[l] = qbit[l] ? trial[l][DIV_W-1:0]
                                          : {rem_reg[l][DIV_W-2:0], dvd_reg[l][DVD_W-1]};
                    dvd_next[l] = {dvd_reg[l][DVD_W-2:0], qbit[l]};
                end
            end
            OP_STORE_AVG: begin
                for (int l = 0; l < LANES; l++) begin
                    avg_next[l] = dvd_reg[l][AVG_W-1:0];
                end
            end
            OP_RSUM: begin
                res_rsi_next         = RSI_FULL;
                res_rdy_next         = 1'b1;
                div_next[LANE_GAIN]  = {1'b0, avg_reg[LANE_GAIN]} + {1'b0, avg_reg[LANE_LOSS]};
            end
            OP_LOAD_RSI: begin
                cnt_next            = CNT_W'(RSI_W);
                rem_next[LANE_GAIN] = DIV_W'(rsi_dvd >> RSI_W);
                dvd_next[LANE_GAIN] = rsi_dvd << (DVD_W - RSI_W);
            end
            OP_STORE_RSI: begin
                res_rsi_next = dvd_reg[LANE_GAIN][RSI_W-1:0];
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    m_valid_next = 1'b1;
                    m_rsi_next   = res_rsi_reg;
                    m_rdy_next   = res_rdy_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // control and series state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= ST_IDLE;
            period_reg  <= PERIOD_RESET;
            prev_reg    <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int l = 0; l < LANES; l++) begin
                avg_reg[l] <= '0;
            end
        end else begin
            pc_reg      <= pc_next;
            period_reg  <= period_next;
            prev_reg    <= prev_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            for (int l = 0; l < LANES; l++) begin
                avg_reg[l] <= avg_next[l];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        close_reg   <= close_next;
        start_reg   <= start_next;
        cnt_reg     <= cnt_next;
        res_rsi_reg <= res_rsi_next;
        res_rdy_reg <= res_rdy_next;
        m_rsi_reg   <= m_rsi_next;
        m_rdy_reg   <= m_rdy_next;
        for (int l = 0; l < LANES; l++) begin
            chg_reg[l] <= chg_next[l];
            dvd_reg[l] <= dvd_next[l];
            rem_reg[l] <= rem_next[l];
            div_reg[l] <= div_next[l];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_rsi_value = m_rsi_reg;
    assign m_ready_res = m_rdy_reg;

    // an accepted beat starts the change step
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> pc_reg == ST_CHANGE)
        else $error("accepted beat did not start the program");

    // divide steps never run off the end of their count
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.op == OP_DIV |-> cnt_reg != '0)
        else $error("divide step with exhausted count");

    // restoring division keeps the partial remainder below the divisor
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.op == OP_DIV |=> rem_reg[LANE_GAIN] < div_reg[LANE_GAIN])
        else $error("partial remainder not below divisor");

    // computed index stays within full scale
    a_rsi_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready_res |-> m_rsi_value <= RSI_FULL)
        else $error("index above full scale");

    // results before warm-up are neutral
    a_neutral: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready_res |-> m_rsi_value == RSI_NEUTRAL)
        else $error("not-ready result is not neutral");

endmodule
